// ===== hw/rtl/rfp_pkg.sv =====
package rfp_pkg;

  localparam logic [7:0] SyncFirst  = 8'hFD;
  localparam logic [7:0] SyncSecond = 8'h07;
  localparam logic [15:0] CrcPoly   = 16'h1021;

  // body byte positions after the preamble
  localparam logic [3:0] BandIdx      = 4'd5;
  localparam logic [3:0] RssiPeakIdx  = 4'd7;
  localparam logic [3:0] RssiFirstIdx = 4'd8;
  localparam logic [3:0] RssiSecIdx   = 4'd9;
  localparam logic [3:0] CrcHighIdx   = 4'd11;
  localparam logic [3:0] CrcLowIdx    = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SYNC = 3'b010,
    ST_BODY = 3'b100
  } hunt_state_t;

  typedef struct packed {
    logic [4:0] band;
    logic [2:0] channel;
    logic [7:0] rssi_peak;
    logic [7:0] rssi_first;
    logic [7:0] rssi_second;
  } rfp_result_t;

  // one byte through CRC-16, poly 0x1021, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  localparam logic [15:0] CrcPreamble = crc_feed(crc_feed(16'h0000, SyncFirst), SyncSecond);

endpackage

// ===== hw/rtl/rfp_parser.sv =====
module rfp_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data,
  output logic                 hit,
  output rfp_pkg::rfp_result_t res
);
  import rfp_pkg::*;

  hunt_state_t state, state_next;
  logic [3:0]  count, count_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  band_chan, band_chan_next;
  logic [7:0]  rssi_peak, rssi_peak_next;
  logic [7:0]  rssi_first, rssi_first_next;
  logic [7:0]  rssi_second, rssi_second_next;
  logic [7:0]  crc_high, crc_high_next;

  always_comb begin
    state_next       = state;
    count_next       = count;
    crc_next         = crc;
    band_chan_next   = band_chan;
    rssi_peak_next   = rssi_peak;
    rssi_first_next  = rssi_first;
    rssi_second_next = rssi_second;
    crc_high_next    = crc_high;
    hit              = 1'b0;
    case (state)
      ST_SYNC: begin
        if (data == SyncSecond) begin
          crc_next   = CrcPreamble;
          count_next = 4'd0;
          state_next = ST_BODY;
        end else begin
          // a second 0xFD is dropped, not a new start
          state_next = ST_IDLE;
        end
      end
      ST_BODY: begin
        if (count >= CrcLowIdx) begin
          state_next = ST_IDLE;
          count_next = 4'd0;
          hit        = ({crc_high, data} == crc);
        end else begin
          if (count == CrcHighIdx) begin
            crc_high_next = data;
          end else begin
            crc_next = crc_feed(crc, data);
            if (count == BandIdx)     band_chan_next   = data;
            if (count == RssiPeakIdx) rssi_peak_next   = data;
            if (count == RssiFirstIdx) rssi_first_next = data;
            if (count == RssiSecIdx)  rssi_second_next = data;
          end
          count_next = count + 4'd1;
        end
      end
      default: begin
        state_next = (data == SyncFirst) ? ST_SYNC : ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= 4'd0;
      crc   <= 16'h0000;
    end else if (step) begin
      state <= state_next;
      count <= count_next;
      crc   <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      band_chan   <= band_chan_next;
      rssi_peak   <= rssi_peak_next;
      rssi_first  <= rssi_first_next;
      rssi_second <= rssi_second_next;
      crc_high    <= crc_high_next;
    end
  end

  assign res.band        = band_chan[7:3];
  assign res.channel     = band_chan[2:0];
  assign res.rssi_peak   = rssi_peak;
  assign res.rssi_first  = rssi_first;
  assign res.rssi_second = rssi_second;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BODY) |-> (count <= CrcLowIdx))
    else $error("body count past last byte");

  a_hit_in_body: assert property (@(posedge clk) disable iff (rst)
    hit |-> (state == ST_BODY) && (count == CrcLowIdx))
    else $error("result outside final body byte");

  a_frame_end_idle: assert property (@(posedge clk) disable iff (rst)
    (step && state == ST_BODY && count == CrcLowIdx) |=> (state == ST_IDLE))
    else $error("parser did not return to idle after frame");

endmodule

// ===== hw/rtl/rfp_out_reg.sv =====
module rfp_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  rfp_pkg::rfp_result_t res_in,
  input  logic                 res_stall,
  output logic                 res_valid,
  output rfp_pkg::rfp_result_t res_out
);
  import rfp_pkg::*;

  logic res_valid_next;

  always_comb begin
    res_valid_next = res_valid;
    if (res_valid && !res_stall) res_valid_next = 1'b0;
    if (load) res_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_out <= res_in;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !(res_valid && res_stall))
    else $error("result overwritten while stalled");

endmodule

// ===== hw/rtl/rssi_frame_parser_crc16_core.sv =====
// channel  | signals                                         | dir
// rx       | rx_valid, rx_stall, rx_byte                     | in
// res      | res_valid, res_stall, band, channel,            | out
//          | rssi_peak, rssi_first, rssi_second              |
//
// One byte a cycle unless the result stalls. A byte is captured in the
// input register, then parsed and CRC-updated as it leaves; a frame's
// result loads with its last byte. Reset clears the hunt state to idle. A
// stalled result holds in the result register while one more byte is taken
// into the input register; rx_stall rises only when both are full.
module rssi_frame_parser_crc16_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [4:0] band,
  output logic [2:0] channel,
  output logic [7:0] rssi_peak,
  output logic [7:0] rssi_first,
  output logic [7:0] rssi_second
);
  import rfp_pkg::*;

  logic        in_full;
  logic [7:0]  in_byte;
  logic        step;
  logic        hit;
  rfp_result_t res_comb;
  rfp_result_t res_q;

  // input register drains whenever the result register can take a beat
  assign step     = in_full && (!res_valid || !res_stall);
  assign rx_stall = in_full && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx_valid && !rx_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) in_byte <= rx_byte;
  end

  rfp_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .data (in_byte),
    .hit  (hit),
    .res  (res_comb)
  );

  rfp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step && hit),
    .res_in    (res_comb),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_out   (res_q)
  );

  assign band        = res_q.band;
  assign channel     = res_q.channel;
  assign rssi_peak   = res_q.rssi_peak;
  assign rssi_first  = res_q.rssi_first;
  assign rssi_second = res_q.rssi_second;

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> in_full && res_valid && res_stall)
    else $error("input stalled with room to take a beat");

  a_step_clears: assert property (@(posedge clk) disable iff (rst)
    (step && !(rx_valid && !rx_stall)) |=> !in_full)
    else $error("input register not drained");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rfp_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 300;

  logic       clk;
  logic       rst;
  logic       rx_valid;
  logic       rx_stall;
  logic [7:0] rx_byte;
  logic       res_valid;
  logic       res_stall;
  logic [4:0] band;
  logic [2:0] channel;
  logic [7:0] rssi_peak;
  logic [7:0] rssi_first;
  logic [7:0] rssi_second;

  rssi_frame_parser_crc16_core u_top (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .band        (band),
    .channel     (channel),
    .rssi_peak   (rssi_peak),
    .rssi_first  (rssi_first),
    .rssi_second (rssi_second)
  );

  // parser shadow state
  hunt_state_t sh_state;
  logic [3:0]  sh_count;
  logic [15:0] sh_crc;
  logic [7:0]  sh_band_ch;
  logic [7:0]  sh_peak;
  logic [7:0]  sh_first;
  logic [7:0]  sh_second;
  logic [7:0]  sh_crc_hi;

  rfp_result_t pending_reports[$];

  bit gaps_on;
  bit hold_req;
  int hold_left;
  int quiet_cycles;
  int bad_reports;
  int reports_seen;
  int bytes_sent;
  int frames_sent;
  int frames_corrupt;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // msb-first CRC-16, one data bit per iteration
  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b);
    rfp_result_t rep;
    case (sh_state)
      ST_SYNC: begin
        if (b == SyncSecond) begin
          sh_crc   = crc16_next(crc16_next(16'h0000, SyncFirst), SyncSecond);
          sh_count = '0;
          sh_state = ST_BODY;
        end else begin
          // a second 0xFD is dropped, not a new start
          sh_state = ST_IDLE;
        end
      end
      ST_BODY: begin
        if (sh_count >= CrcLowIdx) begin
          sh_state = ST_IDLE;
          sh_count = '0;
          if ({sh_crc_hi, b} == sh_crc) begin
            rep.band        = sh_band_ch[7:3];
            rep.channel     = sh_band_ch[2:0];
            rep.rssi_peak   = sh_peak;
            rep.rssi_first  = sh_first;
            rep.rssi_second = sh_second;
            pending_reports.push_back(rep);
          end
        end else begin
          if (sh_count == CrcHighIdx) begin
            sh_crc_hi = b;
          end else begin
            sh_crc = crc16_next(sh_crc, b);
            if (sh_count == BandIdx) sh_band_ch = b;
            else if (sh_count == RssiPeakIdx) sh_peak = b;
            else if (sh_count == RssiFirstIdx) sh_first = b;
            else if (sh_count == RssiSecIdx) sh_second = b;
          end
          sh_count = sh_count + 4'd1;
        end
      end
      default: begin
        sh_state = (b == SyncFirst) ? ST_SYNC : ST_IDLE;
      end
    endcase
  endtask

  // leaves rx_valid high; callers lower it before any wait of their own
  task automatic send_byte(input logic [7:0] b);
    while (gaps_on && $urandom_range(99) < 32) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] band_ch, input logic [7:0] peak,
                            input logic [7:0] first, input logic [7:0] second,
                            input bit corrupt);
    logic [7:0]  body [13];
    logic [15:0] crc;
    int          k;
    for (k = 0; k < 11; k++) body[k] = 8'($urandom_range(255));
    body[BandIdx]      = band_ch;
    body[RssiPeakIdx]  = peak;
    body[RssiFirstIdx] = first;
    body[RssiSecIdx]   = second;
    crc = crc16_next(crc16_next(16'h0000, SyncFirst), SyncSecond);
    for (k = 0; k < 11; k++) crc = crc16_next(crc, body[k]);
    body[CrcHighIdx] = crc[15:8];
    body[CrcLowIdx]  = crc[7:0];
    if (corrupt) begin
      // single bit flip anywhere in the body always breaks the CRC
      k = $urandom_range(12);
      body[k] = body[k] ^ 8'(1 << $urandom_range(7));
      frames_corrupt++;
    end
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    for (k = 0; k < 13; k++) send_byte(body[k]);
    frames_sent++;
  endtask

  task automatic send_random_frame(input bit corrupt);
    send_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)), 8'($urandom_range(255)), corrupt);
  endtask

  // repeated sync byte, then an orphan 0x07 in idle
  task automatic test_preamble_hunt();
    send_byte(SyncFirst);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
  endtask

  task automatic test_field_extremes();
    send_frame(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
    send_frame(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1);
  endtask

  task automatic test_random_traffic(input int byte_goal);
    int r;
    int n;
    while (bytes_sent < byte_goal) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_random_frame(1'b0);
      end else if (r < 80) begin
        send_random_frame(1'b1);
      end else if (r < 88) begin
        send_byte(SyncFirst);
        send_byte(8'($urandom_range(255)));
      end else begin
        n = $urandom_range(4, 1);
        repeat (n) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // receiver holds off while good frames keep coming, so the input side backs up
  task automatic test_backpressure();
    gaps_on = 1'b0;
    rx_valid <= 1'b0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (8) send_random_frame(1'b0);
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else if (hold_req) begin
      hold_left <= HoldCycles;
      res_stall <= 1'b1;
    end else begin
      res_stall <= gaps_on && ($urandom_range(99) < 32);
    end
  end

  always @(posedge clk) begin
    rfp_result_t got;
    rfp_result_t want;
    if (!rst && res_valid && !res_stall) begin
      got.band        = band;
      got.channel     = channel;
      got.rssi_peak   = rssi_peak;
      got.rssi_first  = rssi_first;
      got.rssi_second = rssi_second;
      reports_seen++;
      if (pending_reports.size() == 0) begin
        bad_reports++;
        if (bad_reports <= 10) begin
          $display("%0t: unexpected report band=%0d ch=%0d peak=%0d first=%0d second=%0d",
                   $realtime, got.band, got.channel, got.rssi_peak, got.rssi_first,
                   got.rssi_second);
        end
      end else begin
        want = pending_reports.pop_front();
        if (got.band !== want.band || got.channel !== want.channel ||
            got.rssi_peak !== want.rssi_peak || got.rssi_first !== want.rssi_first ||
            got.rssi_second !== want.rssi_second) begin
          bad_reports++;
          if (bad_reports <= 10) begin
            $display("%0t: report mismatch exp band=%0d ch=%0d peak=%0d first=%0d second=%0d",
                     $realtime, want.band, want.channel, want.rssi_peak, want.rssi_first,
                     want.rssi_second);
            $display("%0t:                 got band=%0d ch=%0d peak=%0d first=%0d second=%0d",
                     $realtime, got.band, got.channel, got.rssi_peak, got.rssi_first,
                     got.rssi_second);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no beat for %0d cycles, %0d reports outstanding",
               QuietLimit, pending_reports.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst       <= 1'b1;
    rx_valid  <= 1'b0;
    rx_byte   <= 8'h00;
    res_stall <= 1'b0;
    hold_req  <= 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    gaps_on = 1'b1;
    sh_state = ST_IDLE;
    sh_count = '0;
    sh_crc = '0;
    sh_band_ch = '0;
    sh_peak = '0;
    sh_first = '0;
    sh_second = '0;
    sh_crc_hi = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_preamble_hunt();
    test_field_extremes();
    test_random_traffic(700);
    gaps_on = 1'b0;
    test_random_traffic(1000);
    gaps_on = 1'b1;
    test_backpressure();
    test_random_traffic(1700);

    rx_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d bytes in %0d frames (%0d with a broken CRC) plus noise and bad preambles",
             bytes_sent, frames_sent, frames_corrupt);
    $display("checked %0d reports, including a %0d-cycle receiver hold-off",
             reports_seen, HoldCycles);
    if (bad_reports == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d report errors", bad_reports);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== rssi_frame_parser_crc16_core.f =====
hw/rtl/rfp_pkg.sv
hw/rtl/rfp_parser.sv
hw/rtl/rfp_out_reg.sv
hw/rtl/rssi_frame_parser_crc16_core.sv
sim/tb.sv
